@@ design/psc_pkg.sv @@
// Package for the periodic substitution cipher.
// Holds sizes, character codes and shared structs; used by every design file but psc_ram.
package psc_pkg;

  // Key table geometry
  localparam int MAX_PERIOD = 16;
  localparam int ALPHABET   = 26;
  localparam int ROW_W      = $clog2(MAX_PERIOD);
  localparam int COL_W      = 5;
  localparam int LETTER_W   = 5;
  localparam int PERIOD_W   = 5;
  localparam int CHAR_W     = 8;
  localparam int ADDR_W     = ROW_W + COL_W;
  localparam int TBL_DEPTH  = MAX_PERIOD * (2 ** COL_W);

  // Function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TEXT = 1'b1;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_NL = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_LO = 8'h20;
  localparam logic [CHAR_W-1:0] CH_HI = 8'h7e;
  localparam logic [CHAR_W-1:0] CH_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_Z  = 8'h7a;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(1);

  // Key table access request
  typedef struct packed {
    logic                we;
    logic [ADDR_W-1:0]   waddr;
    logic [LETTER_W-1:0] wdata;
    logic                re;
    logic [ADDR_W-1:0]   raddr;
  } psc_ram_req_t;

  // Classification of one text word
  typedef struct packed {
    logic              text;
    logic              letter;
    logic              err;
    logic [CHAR_W-1:0] ch;
  } psc_cls_t;

endpackage

@@ design/psc_in_if.sv @@
// Input channel of the periodic substitution cipher: key loads and text.
// Depends on psc_pkg.
interface psc_in_if import psc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                func;
  logic [ROW_W-1:0]    key_row;
  logic [COL_W-1:0]    key_col;
  logic [LETTER_W-1:0] key_letter;
  logic [CHAR_W-1:0]   char_in;

  modport source (output valid, func, key_row, key_col, key_letter, char_in, input ready);
  modport sink   (input valid, func, key_row, key_col, key_letter, char_in, output ready);
endinterface

@@ design/psc_out_if.sv @@
// Result channel of the periodic substitution cipher.
// Depends on psc_pkg.
interface psc_out_if import psc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_out;
  logic              error;

  modport source (output valid, char_out, error, input ready);
  modport sink   (input valid, char_out, error, output ready);
endinterface

@@ design/psc_cfg_if.sv @@
// Configuration write channel: carries the period register value.
// Depends on psc_pkg.
interface psc_cfg_if import psc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [PERIOD_W-1:0] period;

  modport source (output valid, period, input ready);
  modport sink   (input valid, period, output ready);
endinterface

@@ design/periodic_substitution_cipher.sv @@
// Top level of the periodic substitution cipher.
// Depends on psc_pkg, the psc_in_if/psc_out_if/psc_cfg_if interfaces,
// psc_ctrl, psc_stage and psc_ram.
//
// Polyalphabetic substitution over printable ASCII. A word on req with
// func = load writes one key letter into a 16-row by 26-column key table
// (loads with key_col above 25 are dropped and produce no result). A word
// with func = text maps a lowercase letter through the key row selected by
// the running position; other printable characters pass through, newline
// is echoed and returns the position to row 0, and any other byte gives
// error = 1 with char_out = 0 and leaves the position alone. The period
// register (cfg channel, reset 1) sets how many rows are cycled; 0 acts as
// 1 and values above 16 act as 16. Write it only while the block is idle.
// Key entries are undefined until loaded; there is no clearing pass.
// Throughput is one word per cycle for loads and text alike unless a full
// holding stage is stalled by rsp; a text word waits in the holding stage
// while the single registered read port of the key table is read, then its
// result enters the output register; new words enter while it waits on rsp.
module periodic_substitution_cipher import psc_pkg::*; (
  input logic      clk,
  input logic      rst,
  psc_in_if.sink   req,
  psc_out_if.source rsp,
  psc_cfg_if.sink  cfg
);

  logic [PERIOD_W-1:0] period;
  logic                accept;
  logic                s1_free;
  logic [LETTER_W-1:0] rd_data;
  psc_ram_req_t        ram_req;
  psc_cls_t            cls;

  // Config is taken at any time; the user keeps it to idle periods.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= PERIOD_RST;
    end else if (cfg.valid) begin
      period <= cfg.period;
    end
  end

  // A word enters whenever the holding stage is free or moving on.
  assign req.ready = s1_free;
  assign accept    = req.valid && s1_free;

  psc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .period     (period),
    .func       (req.func),
    .key_row    (req.key_row),
    .key_col    (req.key_col),
    .key_letter (req.key_letter),
    .char_in    (req.char_in),
    .ram_req    (ram_req),
    .cls        (cls)
  );

  // Key table: row in the upper address bits, letter column in the lower.
  psc_ram #(
    .WIDTH (LETTER_W),
    .DEPTH (TBL_DEPTH)
  ) u_key_table (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (rd_data)
  );

  // Only text words produce a result, so only they enter the back end.
  psc_stage u_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (accept && cls.text),
    .cls       (cls),
    .rd_data   (rd_data),
    .out_ready (rsp.ready),
    .s1_free   (s1_free),
    .out_valid (rsp.valid),
    .char_out  (rsp.char_out),
    .error     (rsp.error)
  );

endmodule

@@ design/psc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module psc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/psc_ctrl.sv @@
// Front end: classifies the incoming word, tracks the key row position and
// issues key table writes and reads. Depends on psc_pkg.
module psc_ctrl import psc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [PERIOD_W-1:0] period,
  input  logic                func,
  input  logic [ROW_W-1:0]    key_row,
  input  logic [COL_W-1:0]    key_col,
  input  logic [LETTER_W-1:0] key_letter,
  input  logic [CHAR_W-1:0]   char_in,
  output psc_ram_req_t        ram_req,
  output psc_cls_t            cls
);

  logic [ROW_W-1:0]    position;
  logic [ROW_W-1:0]    position_next;
  logic [PERIOD_W-1:0] p_eff;
  logic [ROW_W-1:0]    cur;
  logic [ROW_W:0]      cur_inc;
  logic                is_text;
  logic                is_nl;
  logic                is_print;
  logic                is_letter;
  logic                col_ok;
  logic [COL_W-1:0]    ch_off;

  always_comb begin
    is_text   = (func == FUNC_TEXT);
    is_nl     = (char_in == CH_NL);
    is_print  = (char_in >= CH_LO) && (char_in <= CH_HI);
    is_letter = (char_in >= CH_A) && (char_in <= CH_Z);
    col_ok    = (key_col < COL_W'(ALPHABET));
    ch_off    = COL_W'(char_in - CH_A);

    // period 0 acts as 1, above the table size it saturates
    if (period == '0) begin
      p_eff = PERIOD_W'(1);
    end else if (period > PERIOD_W'(MAX_PERIOD)) begin
      p_eff = PERIOD_W'(MAX_PERIOD);
    end else begin
      p_eff = period;
    end

    // position left beyond a lowered period restarts at row 0
    cur     = (PERIOD_W'(position) < p_eff) ? position : '0;
    cur_inc = {1'b0, cur} + 1'b1;

    position_next = position;
    if (accept && is_text) begin
      if (is_nl) begin
        position_next = '0;
      end else if (is_print) begin
        position_next = (PERIOD_W'(cur_inc) >= p_eff) ? '0 : cur_inc[ROW_W-1:0];
      end
    end

    ram_req.we    = accept && !is_text && col_ok;
    ram_req.waddr = {key_row, key_col};
    ram_req.wdata = key_letter;
    ram_req.re    = accept && is_text;
    ram_req.raddr = {cur, ch_off};

    cls.text   = is_text;
    cls.letter = is_letter;
    cls.err    = !is_nl && !is_print;
    cls.ch     = char_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
    end else begin
      position <= position_next;
    end
  end

`ifndef SYNTHESIS
  a_nl_clears_pos: assert property (@(posedge clk) disable iff (rst)
    accept && is_text && is_nl |=> position == '0)
    else $error("newline did not return position to row 0");

  a_err_holds_pos: assert property (@(posedge clk) disable iff (rst)
    accept && is_text && !is_nl && !is_print |=> $stable(position))
    else $error("invalid byte moved the position");
`endif

endmodule

@@ design/psc_stage.sv @@
// Back end: holds a text word while its key entry is read, then builds the
// result into the output register. Depends on psc_pkg.
module psc_stage import psc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  psc_cls_t            cls,
  input  logic [LETTER_W-1:0] rd_data,
  input  logic                out_ready,
  output logic                s1_free,
  output logic                out_valid,
  output logic [CHAR_W-1:0]   char_out,
  output logic                error
);

  logic              s1_valid;
  psc_cls_t          s1_cls;
  logic              s1_adv;
  logic [CHAR_W-1:0] res;

  always_comb begin
    s1_adv  = s1_valid && (!out_valid || out_ready);
    s1_free = !s1_valid || s1_adv;
    if (s1_cls.letter) begin
      res = CH_A + CHAR_W'(rd_data);
    end else if (s1_cls.err) begin
      res = '0;
    end else begin
      res = s1_cls.ch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_cls <= cls;
    end
    if (s1_adv) begin
      char_out <= res;
      error    <= s1_cls.err;
    end
  end

`ifndef SYNTHESIS
  a_load_fills: assert property (@(posedge clk) disable iff (rst)
    load |=> s1_valid)
    else $error("accepted text word lost before the key read");

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_cls))
    else $error("stalled text word changed");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> char_out == '0)
    else $error("error result carries a nonzero character");
`endif

endmodule

@@ tb/cipher_check.sv @@
`timescale 1ns / 1ps
// Checker for the periodic substitution cipher: watches req, rsp and cfg,
// predicts each text result and compares it with what rsp delivers.
// Depends on psc_pkg and the psc_in_if / psc_out_if / psc_cfg_if interfaces.
module cipher_check import psc_pkg::*; (
  input  logic clk,
  input  logic rst,
  psc_in_if    req,
  psc_out_if   rsp,
  psc_cfg_if   cfg,
  output int   fail_count,
  output int   outstanding,
  output int   results_seen
);

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              err;
  } cipher_out_t;

  logic [LETTER_W-1:0] key_tbl [MAX_PERIOD][ALPHABET];
  int unsigned         row_pos;
  logic [PERIOD_W-1:0] period_q;
  cipher_out_t         cipher_fifo[$];

  function automatic int unsigned active_period();
    if (period_q == '0) return 1;
    if (period_q > MAX_PERIOD) return MAX_PERIOD;
    return period_q;
  endfunction

  // Updates table and position; returns 1 when the word yields a result.
  function automatic bit encipher(input logic func,
                                  input logic [ROW_W-1:0] row,
                                  input logic [COL_W-1:0] col,
                                  input logic [LETTER_W-1:0] letter,
                                  input logic [CHAR_W-1:0] ch,
                                  output cipher_out_t res);
    int unsigned p;
    int unsigned cur;
    res = '0;
    if (func == FUNC_LOAD) begin
      if (col < ALPHABET) key_tbl[row][col] = letter;
      return 1'b0;
    end
    if (ch == CH_NL) begin
      row_pos = 0;
      res.ch  = CH_NL;
      return 1'b1;
    end
    if (ch < CH_LO || ch > CH_HI) begin
      res.err = 1'b1;
      return 1'b1;
    end
    p   = active_period();
    cur = (row_pos < p) ? row_pos : 0;
    res.ch = ch;
    if (ch >= CH_A && ch <= CH_Z) res.ch = CH_A + CHAR_W'(key_tbl[cur][ch - CH_A]);
    row_pos = (cur + 1 >= p) ? 0 : cur + 1;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    cipher_out_t want;
    cipher_out_t got;
    if (rst) begin
      row_pos  = 0;
      period_q = PERIOD_RST;
      cipher_fifo.delete();
      fail_count   <= 0;
      results_seen <= 0;
    end else begin
      // rsp first: a result never belongs to a word taken at the same edge
      if (rsp.valid && rsp.ready) begin
        got.ch  = rsp.char_out;
        got.err = rsp.error;
        results_seen <= results_seen + 1;
        if (cipher_fifo.size() == 0) begin
          $display("%0t: unexpected word on rsp: char_out=%02h error=%0b",
                   $time, got.ch, got.err);
          fail_count <= fail_count + 1;
        end else begin
          want = cipher_fifo.pop_front();
          if (got.ch !== want.ch || got.err !== want.err) begin
            $display("%0t: rsp mismatch: expected char_out=%02h error=%0b, got char_out=%02h error=%0b",
                     $time, want.ch, want.err, got.ch, got.err);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg.valid && cfg.ready) period_q = cfg.period;
      if (req.valid && req.ready &&
          encipher(req.func, req.key_row, req.key_col, req.key_letter, req.char_in, want))
        cipher_fifo.push_back(want);
    end
    outstanding <= cipher_fifo.size();
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Top of the periodic substitution cipher testbench: clock, reset, stimulus
// on req and cfg, rsp back-pressure and the verdict. Checking is done by
// cipher_check. Depends on psc_pkg, the channel interfaces and the design.
module testbench;
  import psc_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_WORDS  = 190;   // 7 phases, about 1330 random words
  localparam int PHASES       = 7;
  localparam int SETTLE       = 4;     // margin for in-flight loads

  logic clk;
  logic rst;

  psc_in_if  req_ch ();
  psc_out_if rsp_ch ();
  psc_cfg_if cfg_ch ();

  int fail_count;
  int outstanding;
  int results_seen;

  // sender bookkeeping
  int burst_left;
  int loads_sent;
  int texts_sent;
  int period_writes;

  periodic_substitution_cipher dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  cipher_check u_check (
    .clk          (clk),
    .rst          (rst),
    .req          (req_ch),
    .rsp          (rsp_ch),
    .cfg          (cfg_ch),
    .fail_count   (fail_count),
    .outstanding  (outstanding),
    .results_seen (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: generous bound on the slowest legal run.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  // rsp back-pressure. Each stretch picks a mode: always ready, mostly
  // ready, a fixed one-in-three pattern, or mostly stalled.
  initial begin
    int mode;
    int span;
    int tick;
    rsp_ch.ready <= 1'b0;
    tick = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(posedge clk);
        tick++;
        case (mode)
          0: rsp_ch.ready <= 1'b1;
          1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
          2: rsp_ch.ready <= (tick % 3 == 0);
          default: rsp_ch.ready <= ($urandom_range(0, 9) == 0);
        endcase
      end
    end
  end

  // One req word. Words go out in bursts; between bursts valid may drop for
  // a random gap, with junk on the payload lines meanwhile.
  task automatic send_word(input logic func,
                           input logic [ROW_W-1:0] row,
                           input logic [COL_W-1:0] col,
                           input logic [LETTER_W-1:0] letter,
                           input logic [CHAR_W-1:0] ch);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_ch.valid      <= 1'b0;
        req_ch.func       <= 1'($urandom);
        req_ch.key_row    <= ROW_W'($urandom);
        req_ch.key_col    <= COL_W'($urandom);
        req_ch.key_letter <= LETTER_W'($urandom);
        req_ch.char_in    <= CHAR_W'($urandom);
        repeat (gap) @(posedge clk);
      end
      // now and then a long burst with no idling at all
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 24);
    end
    burst_left--;
    req_ch.valid      <= 1'b1;
    req_ch.func       <= func;
    req_ch.key_row    <= row;
    req_ch.key_col    <= col;
    req_ch.key_letter <= letter;
    req_ch.char_in    <= ch;
    do @(posedge clk); while (!req_ch.ready);
    if (func == FUNC_LOAD) loads_sent++;
    else texts_sent++;
  endtask

  // Text word: the key fields ride along with random content.
  task automatic send_text(input logic [CHAR_W-1:0] ch);
    send_word(FUNC_TEXT, ROW_W'($urandom), COL_W'($urandom), LETTER_W'($urandom), ch);
  endtask

  // Load word: char_in rides along with random content.
  task automatic send_load(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
                           input logic [LETTER_W-1:0] letter);
    send_word(FUNC_LOAD, row, col, letter, CHAR_W'($urandom));
  endtask

  // Hold off req until every predicted result is back, then let any
  // in-flight load settle.
  task automatic drain_idle();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Period write; callers make sure the block is idle first.
  task automatic write_period(input logic [PERIOD_W-1:0] value);
    cfg_ch.valid  <= 1'b1;
    cfg_ch.period <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    period_writes++;
  endtask

  initial begin
    logic [PERIOD_W-1:0] phase_period [PHASES];
    int counted;
    int r;
    int s;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
    logic [LETTER_W-1:0] letter;
    logic [CHAR_W-1:0]   ch;

    burst_left    = 0;
    loads_sent    = 0;
    texts_sent    = 0;
    period_writes = 0;

    // every input known from time zero
    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.func       <= FUNC_LOAD;
    req_ch.key_row    <= '0;
    req_ch.key_col    <= '0;
    req_ch.key_letter <= '0;
    req_ch.char_in    <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.period     <= PERIOD_RST;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Fill the whole key table so no letter ever maps through an unwritten
    // entry. Letters stay in a..z here; out-of-range ones come later.
    for (int i = 0; i < MAX_PERIOD; i++)
      for (int j = 0; j < ALPHABET; j++)
        send_load(ROW_W'(i), COL_W'(j), LETTER_W'($urandom_range(0, ALPHABET - 1)));

    // ---- directed ----
    drain_idle();
    write_period(PERIOD_W'(MAX_PERIOD));
    send_text(CH_A);                    // lowest letter
    send_text(CH_Z);                    // highest letter
    send_text(CH_LO);                   // printable edges pass through
    send_text(CH_HI);
    send_text(CH_LO - 8'd1);            // just below printable: error
    send_text(CH_HI + 8'd1);            // just above printable: error
    send_text(8'h00);
    send_text(8'hff);
    send_text(CH_NL);                   // echo and back to row 0
    for (int k = 0; k < 6; k++) send_text(CH_A + CHAR_W'(12 + k));

    // period lowered below the running position: next char uses row 0
    drain_idle();
    write_period(PERIOD_W'(3));
    send_text(CH_A + 8'd23);
    send_text(CH_A + 8'd24);

    // loads with the column out of range are dropped
    send_load('0, COL_W'(ALPHABET), LETTER_W'(5));
    send_load('0, '1, '1);
    // substitute above z is stored as given: 'a' maps to 0x80
    send_load('0, '0, '1);
    send_text(CH_NL);
    send_text(CH_A);

    // period 0 behaves as 1
    drain_idle();
    write_period('0);
    send_text(CH_A + 8'd1);
    send_text(CH_A + 8'd2);

    // ---- random phases, one period setting each ----
    phase_period[0] = PERIOD_W'(1);
    phase_period[1] = '1;                       // 31 clamps to 16
    phase_period[2] = PERIOD_W'(MAX_PERIOD + 1);
    phase_period[3] = '0;
    phase_period[4] = PERIOD_W'(MAX_PERIOD);
    phase_period[5] = PERIOD_W'($urandom_range(2, MAX_PERIOD - 1));
    phase_period[6] = PERIOD_W'($urandom);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_idle();
      write_period(phase_period[ph]);
      counted = 0;
      while (counted < PHASE_WORDS) begin
        r = $urandom_range(0, 99);
        if (r < 18) begin
          row    = ROW_W'($urandom);
          col    = ($urandom_range(0, 9) == 0) ? COL_W'($urandom_range(ALPHABET, 31))
                                               : COL_W'($urandom_range(0, ALPHABET - 1));
          letter = ($urandom_range(0, 9) == 0) ? LETTER_W'($urandom_range(ALPHABET, 31))
                                               : LETTER_W'($urandom_range(0, ALPHABET - 1));
          send_load(row, col, letter);
          if (col < ALPHABET) counted++;   // dropped loads do not count
        end else begin
          // mostly lowercase text, some punctuation, newlines and bad bytes
          s = $urandom_range(0, 99);
          if (s < 60)      ch = CH_A + CHAR_W'($urandom_range(0, ALPHABET - 1));
          else if (s < 80) ch = CHAR_W'($urandom_range(CH_LO, CH_HI));
          else if (s < 88) ch = CH_NL;
          else if (s < 94) ch = CHAR_W'($urandom_range(0, CH_LO - 1));
          else             ch = CHAR_W'($urandom_range(CH_HI + 1, 255));
          send_text(ch);
          counted++;
        end
        // occasional full stop until the pipe is empty
        if ($urandom_range(0, 299) == 0) drain_idle();
      end
    end

    // ---- wind down ----
    drain_idle();
    repeat (10) @(posedge clk);

    $display("Covered %0d key loads and %0d text words over %0d period settings,",
             loads_sent, texts_sent, period_writes);
    $display("with %0d rsp words compared against prediction.", results_seen);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
